FILE: design/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// shared constants, codes and control types
// ----------------------------------------------------------------------------
package pwg_pkg;

    // quarter-wave table depth, a power of two
    localparam int SINE_TABLE_DEPTH  = 256;
    localparam int SINE_IDX_W        = $clog2(SINE_TABLE_DEPTH);
    localparam int TAB_W             = 17;

    localparam int DEF_FRACTION_BITS = 8;

    localparam int AMP_W      = 16;
    localparam int MID_W      = 16;
    localparam int PERIOD_W   = 16;
    localparam int PHASE_W    = 17;
    localparam int SAMPLE_W   = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] WAVE_SQUARE   = 2'd0;
    localparam logic [1:0] WAVE_SINE     = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_TYPE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MID_VALUE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_SAMPLES = 2'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2;

    // pi/2 in q30
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1073741824;

    typedef struct packed {
        logic [1:0]          wave_type;
        logic [MID_W-1:0]    mid_value;
        logic [AMP_W-1:0]    amplitude;
        logic [PERIOD_W-1:0] period_samples;
    } pwg_cfg_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_start;
        logic tab;
        logic smul;
        logic finish;
    } pwg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_square;
        logic is_sine;
    } pwg_status_t;

endpackage

FILE: design/pwg_in_if.sv
// ----------------------------------------------------------------------------
// pwg_in_if
// tick channel: one beat asks for one sample
// ----------------------------------------------------------------------------
interface pwg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

FILE: design/pwg_out_if.sv
// ----------------------------------------------------------------------------
// pwg_out_if
// sample channel: one beat carries one waveform sample
// ----------------------------------------------------------------------------
interface pwg_out_if;
    import pwg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       period_start;

    modport source (output valid, output sample, output period_start, input ready);
    modport sink   (input valid, input sample, input period_start, output ready);
endinterface

FILE: design/pwg_div.sv
// ----------------------------------------------------------------------------
// pwg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pwg_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 17,
    parameter int QUOT_W     = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);
    localparam int CNT_W = $clog2(QUOT_W);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]    quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUOT_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper part is below the divisor by construction
            rem_next  = dividend[QUOT_W +: DIVISOR_W];
            quo_next  = dividend[QUOT_W-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[QUOT_W-2:0], ge};
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a run");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= CNT_W'(QUOT_W - 1)))
        else $error("divider step count out of range");
`endif

endmodule

FILE: design/pwg_dp.sv
// ----------------------------------------------------------------------------
// pwg_dp
// phase counter, shared multiplier, divider, sine table and output register
// ----------------------------------------------------------------------------
module pwg_dp #(
    parameter int FRACTION_BITS = pwg_pkg::DEF_FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pwg_pkg::pwg_cmd_t                   cmd,
    output pwg_pkg::pwg_status_t                status,
    input  pwg_pkg::pwg_cfg_t                   cfg,
    input  logic                                restart,
    output logic signed [pwg_pkg::SAMPLE_W-1:0] sample,
    output logic                                period_start
);
    import pwg_pkg::*;

    localparam int AMP_FX_W   = AMP_W + FRACTION_BITS;
    localparam int QUOT_W     = AMP_FX_W;
    localparam int PROD_W     = AMP_W + PHASE_W;
    localparam int DIVIDEND_W = PROD_W + FRACTION_BITS + 1;
    localparam int DIVISOR_W  = PERIOD_W + 1;
    localparam int SMAG_W     = PROD_W + FRACTION_BITS + 1;
    localparam int VAL_W      = (AMP_FX_W + 3 > SAMPLE_W + 1) ? AMP_FX_W + 3 : SAMPLE_W + 1;
    localparam int IDX_W      = SINE_IDX_W + 1;

    localparam logic signed [VAL_W-1:0] SAT_MAX = VAL_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [VAL_W-1:0] SAT_MIN = VAL_W'(-(2 ** (SAMPLE_W - 1)));

    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [PHASE_W-1:0]  ph_reg;
    logic                first_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TAB_W-1:0]    tab_reg;
    logic [1:0]          quad_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                start_out_reg;

    logic [PERIOD_W-1:0] period_eff;
    logic [PHASE_W-1:0]  cycle_len;
    logic [PHASE_W-1:0]  ph_inc;
    logic [PHASE_W:0]    u;
    logic [PHASE_W:0]    w;
    logic [PHASE_W-1:0]  mul_b;
    logic [PROD_W-1:0]   amp_prod;
    logic [PROD_W-1:0]   sine_num;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic                div_done;
    logic [QUOT_W-1:0]   quotient;
    logic [SINE_IDX_W+1:0] k;
    logic [IDX_W-1:0]    tab_idx;
    logic [TAB_W-1:0]    sine_rom [0:SINE_TABLE_DEPTH];
    logic signed [VAL_W-1:0] m_fx;
    logic signed [VAL_W-1:0] a_fx;
    logic signed [VAL_W-1:0] low;
    logic signed [VAL_W-1:0] high;
    logic [SMAG_W-1:0]   smag_full;
    logic signed [VAL_W-1:0] smag;
    logic signed [VAL_W-1:0] quo_ext;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] value_sat;
    logic                is_square;
    logic                is_sine;
    logic                is_triangle;

    // quarter-wave table, built at elaboration
    // 65536*sin(pi/2*idx/depth) from an 8-term taylor series in q30
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        localparam longint X  = (PI_HALF_Q30 * longint'(g) + longint'(SINE_TABLE_DEPTH / 2))
                                / longint'(SINE_TABLE_DEPTH);
        localparam longint X2 = (X * X) >>> 30;
        localparam longint T1 = -((X  * X2) / 64'sd6)   / Q30_ONE;
        localparam longint T2 = -((T1 * X2) / 64'sd20)  / Q30_ONE;
        localparam longint T3 = -((T2 * X2) / 64'sd42)  / Q30_ONE;
        localparam longint T4 = -((T3 * X2) / 64'sd72)  / Q30_ONE;
        localparam longint T5 = -((T4 * X2) / 64'sd110) / Q30_ONE;
        localparam longint T6 = -((T5 * X2) / 64'sd156) / Q30_ONE;
        localparam longint T7 = -((T6 * X2) / 64'sd210) / Q30_ONE;
        localparam longint SUM   = X + T1 + T2 + T3 + T4 + T5 + T6 + T7;
        localparam longint SUM_C = (SUM < 0) ? 64'sd0 : SUM;
        localparam longint Q16   = (SUM_C + 64'sd8192) >>> 14;
        localparam longint Q16_C = (Q16 > 64'sd65536) ? 64'sd65536 : Q16;
        localparam logic [TAB_W-1:0] ENTRY = TAB_W'(Q16_C);
        assign sine_rom[g] = ENTRY;
    end

    assign is_square   = (cfg.wave_type == WAVE_SQUARE);
    assign is_sine     = (cfg.wave_type == WAVE_SINE);
    assign is_triangle = (cfg.wave_type == WAVE_TRIANGLE);

    assign period_eff = (cfg.period_samples < PERIOD_MIN) ? PERIOD_MIN : cfg.period_samples;
    assign cycle_len  = is_square ? {period_eff, 1'b0} : {1'b0, period_eff};
    assign ph_inc     = ph_reg + 1'b1;

    // triangle folds the doubled phase back after the half period
    assign u     = {ph_reg, 1'b0};
    assign w     = (u <= (PHASE_W + 1)'(period_eff)) ?
                   u : ((PHASE_W + 1)'({period_eff, 1'b0}) - u);
    assign mul_b = cmd.smul ? tab_reg : (is_triangle ? w[PHASE_W-1:0] : ph_reg);
    assign amp_prod = PROD_W'(cfg.amplitude) * PROD_W'(mul_b);
    assign sine_num = PROD_W'(ph_reg) << (SINE_IDX_W + 2);

    assign dividend = is_sine ? DIVIDEND_W'(prod_reg)
                              : ((DIVIDEND_W'(prod_reg) << (FRACTION_BITS + 1))
                                 + DIVIDEND_W'(period_eff));
    assign divisor  = is_sine ? {1'b0, period_eff} : {period_eff, 1'b0};

    pwg_div #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W),
        .QUOT_W     (QUOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign k       = quotient[SINE_IDX_W+1:0];
    assign tab_idx = k[SINE_IDX_W] ? (IDX_W'(SINE_TABLE_DEPTH) - {1'b0, k[SINE_IDX_W-1:0]})
                                   : {1'b0, k[SINE_IDX_W-1:0]};

    // levels and the final sample
    always_comb
    begin
        m_fx      = VAL_W'($signed(cfg.mid_value)) <<< FRACTION_BITS;
        a_fx      = VAL_W'(cfg.amplitude) << FRACTION_BITS;
        low       = m_fx - (a_fx >>> 1);
        high      = low + a_fx;
        smag_full = ((SMAG_W'(prod_reg) << FRACTION_BITS) + SMAG_W'(65536)) >> 17;
        smag      = VAL_W'(smag_full);
        quo_ext   = VAL_W'(quotient);
        unique case (cfg.wave_type)
            WAVE_SQUARE:   value = (ph_reg < {1'b0, period_eff}) ? high : low;
            WAVE_SINE:     value = quad_reg[1] ? (m_fx - smag) : (m_fx + smag);
            WAVE_TRIANGLE: value = low + quo_ext;
            WAVE_SAWTOOTH: value = low + quo_ext;
            default:       value = low;
        endcase
        priority if (value > SAT_MAX)
        begin
            value_sat = SAT_MAX;
        end
        else if (value < SAT_MIN)
        begin
            value_sat = SAT_MIN;
        end
        else
        begin
            value_sat = value;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.prep)
        begin
            phase_next = (ph_inc >= cycle_len) ? '0 : ph_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ph_reg <= (restart || (phase_reg >= cycle_len)) ? '0 : phase_reg;
        end
        if (cmd.prep)
        begin
            first_reg <= (ph_reg == '0);
        end
        if (cmd.prep || cmd.smul)
        begin
            prod_reg <= (cmd.prep && is_sine) ? sine_num : amp_prod;
        end
        if (cmd.tab)
        begin
            tab_reg  <= sine_rom[tab_idx];
            quad_reg <= k[SINE_IDX_W+1:SINE_IDX_W];
        end
        if (cmd.finish)
        begin
            sample_reg    <= value_sat[SAMPLE_W-1:0];
            start_out_reg <= first_reg;
        end
    end

    assign status.div_done  = div_done;
    assign status.is_square = is_square;
    assign status.is_sine   = is_sine;
    assign sample           = sample_reg;
    assign period_start     = start_out_reg;

endmodule

FILE: design/pwg_ctrl.sv
// ----------------------------------------------------------------------------
// pwg_ctrl
// sequencer for one sample and owner of the output beat valid
// ----------------------------------------------------------------------------
module pwg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  pwg_pkg::pwg_status_t status,
    output pwg_pkg::pwg_cmd_t    cmd
);
    import pwg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIVGO = 3'd2;
    localparam logic [2:0] ST_DIVW  = 3'd3;
    localparam logic [2:0] ST_TAB   = 3'd4;
    localparam logic [2:0] ST_SMUL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = (state_reg == ST_IDLE);
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.is_square ? ST_DONE : ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                begin
                    state_next = status.is_sine ? ST_TAB : ST_DONE;
                end
            end
            ST_TAB:
            begin
                cmd.tab    = 1'b1;
                state_next = ST_SMUL;
            end
            ST_SMUL:
            begin
                cmd.smul   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted beat not prepared");
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_DIVW))
        else $error("divider done outside wait state");
`endif

endmodule

FILE: design/periodic_waveform_generator.sv
// ----------------------------------------------------------------------------
// periodic_waveform_generator
// square, sine, triangle and sawtooth sample generator with a phase counter
// ----------------------------------------------------------------------------
// Each beat on tick yields one beat on result carrying one signed sample with
// FRACTION_BITS fraction bits, saturated to 25 bits, plus a flag for the first
// sample of a cycle. A tick with restart set clears the phase before its
// sample. Only one tick is in work at a time; a finished sample waits in the
// output register, so the next tick is taken while it is still unread. The
// square wave needs no division; triangle, sawtooth and sine wait for the
// restoring divider that yields one quotient bit a cycle (16 + FRACTION_BITS
// bits), and the sine adds one table read and one multiply after it.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and take effect on the next tick; write them only while no tick is in work.
// ----------------------------------------------------------------------------
module periodic_waveform_generator #(
    parameter int FRACTION_BITS = pwg_pkg::DEF_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pwg_in_if.sink                             tick,
    pwg_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [pwg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pwg_pkg::*;

    // configuration registers
    logic [1:0]          wave_type_reg;
    logic [MID_W-1:0]    mid_value_reg;
    logic [AMP_W-1:0]    amplitude_reg;
    logic [PERIOD_W-1:0] period_samples_reg;

    pwg_cfg_t    cfg;
    pwg_cmd_t    cmd;
    pwg_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg      <= WAVE_SQUARE;
            mid_value_reg      <= '0;
            amplitude_reg      <= '0;
            period_samples_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAVE_TYPE:      wave_type_reg      <= cfg_data[1:0];
                REG_MID_VALUE:      mid_value_reg      <= cfg_data[MID_W-1:0];
                REG_AMPLITUDE:      amplitude_reg      <= cfg_data[AMP_W-1:0];
                REG_PERIOD_SAMPLES: period_samples_reg <= cfg_data[PERIOD_W-1:0];
                default:            wave_type_reg      <= wave_type_reg;
            endcase
        end
    end

    assign cfg.wave_type      = wave_type_reg;
    assign cfg.mid_value      = mid_value_reg;
    assign cfg.amplitude      = amplitude_reg;
    assign cfg.period_samples = period_samples_reg;

    // sequencer: accepts a tick, steps the datapath, holds the result beat
    pwg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (tick.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // phase counter, arithmetic and output register
    pwg_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .restart      (tick.restart),
        .sample       (result.sample),
        .period_start (result.period_start)
    );

endmodule
